// ===== design/rrsp_pkg.sv =====
// Package with shared constants, codes and types for the RESP reply stream parser.
package rrsp_pkg;

   localparam int PENDING_WIDTH_DEFAULT = 32;
   localparam int MAX_INT_CHARS_DEFAULT = 30;
   localparam logic [30:0] ARRAY_RESET_LIMIT = 31'(4 * 1024 * 1024);

   typedef enum logic [3:0] {
      PH_START    = 4'd0,
      PH_TYPE     = 4'd1,
      PH_LINE     = 4'd2,
      PH_NUM_LEAD = 4'd3,
      PH_NUM_DIG  = 4'd4,
      PH_NUM_STOP = 4'd5,
      PH_BULK     = 4'd6,
      PH_BULK_CR  = 4'd7,
      PH_BULK_LF  = 4'd8,
      PH_INLINE   = 4'd9
   } phase_type;

   localparam logic [2:0] T_STATUS = 3'd0;
   localparam logic [2:0] T_ERROR  = 3'd1;
   localparam logic [2:0] T_INT    = 3'd2;
   localparam logic [2:0] T_BULK   = 3'd3;
   localparam logic [2:0] T_NULL   = 3'd4;
   localparam logic [2:0] T_ARRAY  = 3'd5;
   localparam logic [2:0] T_INLINE = 3'd6;

   localparam logic [1:0] EV_HEAD = 2'd0;
   localparam logic [1:0] EV_DATA = 2'd1;
   localparam logic [1:0] EV_END  = 2'd2;
   localparam logic [1:0] EV_ERR  = 2'd3;

   localparam logic [2:0] ERR_TYPE   = 3'd0;
   localparam logic [2:0] ERR_INT    = 3'd1;
   localparam logic [2:0] ERR_LEN    = 3'd2;
   localparam logic [2:0] ERR_CRLF   = 3'd3;
   localparam logic [2:0] ERR_ARRAY  = 3'd4;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [63:0] MAG_CAP = 64'h8000_0000_0000_0000;

   // One result event.
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  rtype;
      logic [63:0] value;
      logic [7:0]  pbyte;
      logic        done;
      logic [2:0]  code;
   } event_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'd48 && b <= 8'd57;
   endfunction

   function automatic event_type mk_ev(input logic [1:0] k, input logic [2:0] t,
                                       input logic [63:0] v, input logic [7:0] pb,
                                       input logic d, input logic [2:0] c);
      event_type e;
      e.kind = k; e.rtype = t; e.value = v; e.pbyte = pb; e.done = d; e.code = c;
      return e;
   endfunction

endpackage

// ===== design/rrsp_engine.sv =====
// Parser state and per-byte decode: one byte in, up to two events out per step.
module rrsp_engine #(
   parameter int PENDING_WIDTH = rrsp_pkg::PENDING_WIDTH_DEFAULT,
   parameter int MAX_INT_CHARS = rrsp_pkg::MAX_INT_CHARS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            data_byte,
   input  logic [30:0]           max_array_count,
   output logic [1:0]            ev_count,
   output rrsp_pkg::event_type   ev0,
   output rrsp_pkg::event_type   ev1
);
   import rrsp_pkg::*;

   localparam int LL_W = $clog2(MAX_INT_CHARS + 2);
   localparam logic [LL_W-1:0] LL_MAX = LL_W'(MAX_INT_CHARS);
   localparam logic [PENDING_WIDTH-1:0] PEND_MAX = '1;

   phase_type phase_ff, phase_in;
   logic [2:0]  line_type_ff, line_type_in;
   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic [LL_W-1:0] llen_ff, llen_in;
   logic        fdig_ff, fdig_in;
   logic [30:0] bulk_ff, bulk_in;
   logic [PENDING_WIDTH-1:0] pend_ff, pend_in;
   logic        hcr_ff, hcr_in;
   logic        intok_ff, intok_in;
   logic [31:0] tcnt_ff, tcnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         line_type_ff <= '0;
         acc_ff <= '0;
         neg_ff <= 1'b0;
         llen_ff <= '0;
         fdig_ff <= 1'b0;
         bulk_ff <= '0;
         pend_ff <= PENDING_WIDTH'(1);
         hcr_ff <= 1'b0;
         intok_ff <= 1'b0;
         tcnt_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         line_type_ff <= line_type_in;
         acc_ff <= acc_in;
         neg_ff <= neg_in;
         llen_ff <= llen_in;
         fdig_ff <= fdig_in;
         bulk_ff <= bulk_in;
         pend_ff <= pend_in;
         hcr_ff <= hcr_in;
         intok_ff <= intok_in;
         tcnt_ff <= tcnt_in;
      end
   end

   // Decoded number values, from the accumulator, pending count and input byte.
   logic [63:0] int_val;
   logic [63:0] n31;
   logic        n31_neg;
   logic        n31_zero;
   logic [PENDING_WIDTH-1:0] pend_dec;
   logic        pend_last;
   logic [63:0] add_m1;
   logic [64:0] pend_sum;
   logic [63:0] mul10;
   logic [63:0] dig;
   logic        dig_ovf;

   always_comb begin
      int_val = neg_ff ? (64'd0 - acc_ff) : (acc_ff[63] ? (MAG_CAP - 64'd1) : acc_ff);
      if (neg_ff) begin
         n31 = (acc_ff > 64'd2147483648) ? 64'hFFFF_FFFF_8000_0000 : (64'd0 - acc_ff);
      end else begin
         n31 = (acc_ff > 64'd2147483647) ? 64'd2147483647 : acc_ff;
      end
      n31_neg = n31[63];
      n31_zero = (n31 == 64'd0);
      pend_dec = (pend_ff != '0) ? pend_ff - PENDING_WIDTH'(1) : pend_ff;
      pend_last = (pend_dec == '0);
      add_m1 = n31 - 64'd1;
      pend_sum = {{(65 - PENDING_WIDTH){1'b0}}, pend_ff} + {1'b0, add_m1};
      dig = {56'd0, data_byte - 8'd48};
      mul10 = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0};
      // Overflow when acc > (2^63 - d) / 10.
      dig_ovf = (acc_ff > 64'd922337203685477580) ||
                (acc_ff == 64'd922337203685477580 && dig > 64'd8);
   end

   // Next state and events.
   always_comb begin
      logic [7:0] b;
      logic       num_path;
      logic       two_chars;
      logic [LL_W-1:0] ll;
      logic [63:0] acc;
      logic       ng;
      logic       fd;
      phase_type  ph;
      logic [63:0] d;
      b = data_byte;
      num_path = 1'b0;
      two_chars = 1'b0;
      ll = llen_ff;
      acc = acc_ff;
      ng = neg_ff;
      fd = fdig_ff;
      ph = phase_ff;
      d = 64'd0;

      phase_in = phase_ff;
      line_type_in = line_type_ff;
      acc_in = acc_ff;
      neg_in = neg_ff;
      llen_in = llen_ff;
      fdig_in = fdig_ff;
      bulk_in = bulk_ff;
      pend_in = pend_ff;
      hcr_in = hcr_ff;
      intok_in = intok_ff;
      tcnt_in = tcnt_ff;
      ev_count = 2'd0;
      ev0 = '0;
      ev1 = '0;

      unique case (phase_ff)
         PH_START, PH_TYPE: begin
            hcr_in = 1'b0;
            if (b == CH_PLUS || b == CH_MINUS) begin
               line_type_in = (b == CH_PLUS) ? T_STATUS : T_ERROR;
               phase_in = PH_LINE;
               ev_count = 2'd1;
               ev0 = mk_ev(EV_HEAD, line_type_in, 64'd0, 8'd0, 1'b0, 3'd0);
            end else if (b == CH_COLON || b == CH_DOLLAR || b == CH_STAR) begin
               line_type_in = (b == CH_COLON) ? T_INT : (b == CH_DOLLAR) ? T_BULK : T_ARRAY;
               phase_in = PH_NUM_LEAD;
               acc_in = '0;
               neg_in = 1'b0;
               llen_in = '0;
               fdig_in = 1'b0;
            end else if (phase_ff == PH_START && (is_alpha(b) || is_space(b))) begin
               // First inline byte: the line counters start from zero.
               intok_in = 1'b0;
               tcnt_in = '0;
               if (b == CH_LF) begin
                  phase_in = PH_START;
                  pend_in = PENDING_WIDTH'(1);
               end else if (is_space(b)) begin
                  phase_in = PH_INLINE;
               end else begin
                  phase_in = PH_INLINE;
                  tcnt_in = 32'd1;
                  intok_in = 1'b1;
                  ev_count = 2'd2;
                  ev0 = mk_ev(EV_HEAD, T_INLINE, 64'd1, 8'd0, 1'b0, 3'd0);
                  ev1 = mk_ev(EV_DATA, T_INLINE, 64'd0, b, 1'b0, 3'd0);
               end
            end else begin
               ev_count = 2'd1;
               ev0 = mk_ev(EV_ERR, 3'd0, 64'd0, 8'd0, 1'b0, ERR_TYPE);
               phase_in = PH_START;
               pend_in = PENDING_WIDTH'(1);
               intok_in = 1'b0;
               tcnt_in = '0;
            end
         end
         PH_LINE, PH_NUM_LEAD, PH_NUM_DIG, PH_NUM_STOP: begin
            if (hcr_ff && b == CH_LF) begin
               hcr_in = 1'b0;
               if (phase_ff == PH_LINE) begin
                  pend_in = pend_dec;
                  ev_count = 2'd1;
                  ev0 = mk_ev(EV_END, line_type_ff, 64'd0, 8'd0, pend_last, 3'd0);
                  phase_in = pend_last ? PH_START : PH_TYPE;
                  if (pend_last) pend_in = PENDING_WIDTH'(1);
               end else if (line_type_ff == T_INT) begin
                  if (llen_ff == '0 || llen_ff > LL_MAX) begin
                     ev_count = 2'd1;
                     ev0 = mk_ev(EV_ERR, 3'd0, 64'd0, 8'd0, 1'b0, ERR_INT);
                     phase_in = PH_START;
                     pend_in = PENDING_WIDTH'(1);
                  end else begin
                     ev_count = 2'd2;
                     ev0 = mk_ev(EV_HEAD, T_INT, int_val, 8'd0, 1'b0, 3'd0);
                     ev1 = mk_ev(EV_END, T_INT, int_val, 8'd0, pend_last, 3'd0);
                     pend_in = pend_last ? PENDING_WIDTH'(1) : pend_dec;
                     phase_in = pend_last ? PH_START : PH_TYPE;
                  end
               end else if (n31_neg) begin
                  ev_count = 2'd2;
                  ev0 = mk_ev(EV_HEAD, T_NULL, n31, 8'd0, 1'b0, 3'd0);
                  ev1 = mk_ev(EV_END, T_NULL, n31, 8'd0, pend_last, 3'd0);
                  pend_in = pend_last ? PENDING_WIDTH'(1) : pend_dec;
                  phase_in = pend_last ? PH_START : PH_TYPE;
               end else if (n31_zero && !fdig_ff) begin
                  ev_count = 2'd1;
                  ev0 = mk_ev(EV_ERR, 3'd0, 64'd0, 8'd0, 1'b0, ERR_LEN);
                  phase_in = PH_START;
                  pend_in = PENDING_WIDTH'(1);
               end else if (line_type_ff == T_BULK) begin
                  acc_in = n31;
                  ev_count = 2'd1;
                  ev0 = mk_ev(EV_HEAD, T_BULK, n31, 8'd0, 1'b0, 3'd0);
                  if (n31_zero) begin
                     phase_in = PH_BULK_CR;
                  end else begin
                     bulk_in = n31[30:0];
                     phase_in = PH_BULK;
                  end
               end else if (n31 > {33'd0, max_array_count}) begin
                  ev_count = 2'd1;
                  ev0 = mk_ev(EV_ERR, 3'd0, 64'd0, 8'd0, 1'b0, ERR_ARRAY);
                  phase_in = PH_START;
                  pend_in = PENDING_WIDTH'(1);
               end else begin
                  ev0 = mk_ev(EV_HEAD, T_ARRAY, n31, 8'd0, 1'b0, 3'd0);
                  if (n31_zero) begin
                     ev_count = 2'd2;
                     ev1 = mk_ev(EV_END, T_ARRAY, 64'd0, 8'd0, pend_last, 3'd0);
                     pend_in = pend_last ? PENDING_WIDTH'(1) : pend_dec;
                     phase_in = pend_last ? PH_START : PH_TYPE;
                  end else begin
                     ev_count = 2'd1;
                     if (pend_sum > {{(65 - PENDING_WIDTH){1'b0}}, PEND_MAX}) begin
                        pend_in = PEND_MAX;
                     end else begin
                        pend_in = pend_sum[PENDING_WIDTH-1:0];
                     end
                     phase_in = PH_TYPE;
                  end
               end
            end else begin
               // Ordinary line characters: a held CR first, then this byte unless CR.
               hcr_in = (b == CH_CR);
               two_chars = hcr_ff && (b != CH_CR);
               if (phase_ff == PH_LINE) begin
                  if (hcr_ff) begin
                     ev0 = mk_ev(EV_DATA, line_type_ff, 64'd0, CH_CR, 1'b0, 3'd0);
                     ev1 = mk_ev(EV_DATA, line_type_ff, 64'd0, b, 1'b0, 3'd0);
                     ev_count = two_chars ? 2'd2 : 2'd1;
                  end else if (b != CH_CR) begin
                     ev_count = 2'd1;
                     ev0 = mk_ev(EV_DATA, line_type_ff, 64'd0, b, 1'b0, 3'd0);
                  end
               end else begin
                  num_path = hcr_ff || (b != CH_CR);
                  // A held CR is no digit; it adds to length and moves scan phases.
                  if (hcr_ff) begin
                     if (ll == '0) fd = 1'b0;
                     if (ll <= LL_MAX) ll = ll + LL_W'(1);
                     if (ph == PH_NUM_LEAD) begin
                        if (!is_space(CH_CR)) ph = PH_NUM_STOP;
                     end else if (ph == PH_NUM_DIG) begin
                        ph = PH_NUM_STOP;
                     end
                  end
                  if (num_path && b != CH_CR) begin
                     if (ll == '0) fd = is_digit(b);
                     if (ll <= LL_MAX) ll = ll + LL_W'(1);
                     if (ph == PH_NUM_LEAD) begin
                        if (is_space(b)) begin
                           ph = PH_NUM_LEAD;
                        end else if (b == CH_PLUS) begin
                           ph = PH_NUM_DIG;
                        end else if (b == CH_MINUS) begin
                           ng = 1'b1;
                           ph = PH_NUM_DIG;
                        end else if (is_digit(b)) begin
                           acc = {56'd0, b - 8'd48};
                           ph = PH_NUM_DIG;
                        end else begin
                           ph = PH_NUM_STOP;
                        end
                     end else if (ph == PH_NUM_DIG) begin
                        if (is_digit(b) && !hcr_ff) begin
                           d = dig;
                           acc = dig_ovf ? MAG_CAP : (mul10 + d);
                        end else begin
                           ph = PH_NUM_STOP;
                        end
                     end
                  end
                  llen_in = ll;
                  fdig_in = fd;
                  acc_in = acc;
                  neg_in = ng;
                  phase_in = ph;
               end
            end
         end
         PH_BULK: begin
            ev_count = 2'd1;
            ev0 = mk_ev(EV_DATA, T_BULK, 64'd0, b, 1'b0, 3'd0);
            bulk_in = (bulk_ff != '0) ? bulk_ff - 31'd1 : bulk_ff;
            if (bulk_in == '0) phase_in = PH_BULK_CR;
         end
         PH_BULK_CR: begin
            if (b == CH_CR) begin
               phase_in = PH_BULK_LF;
            end else begin
               ev_count = 2'd1;
               ev0 = mk_ev(EV_ERR, 3'd0, 64'd0, 8'd0, 1'b0, ERR_CRLF);
               phase_in = PH_START;
               pend_in = PENDING_WIDTH'(1);
               hcr_in = 1'b0;
               intok_in = 1'b0;
               tcnt_in = '0;
            end
         end
         PH_BULK_LF: begin
            ev_count = 2'd1;
            hcr_in = 1'b0;
            if (b == CH_LF) begin
               ev0 = mk_ev(EV_END, T_BULK, acc_ff, 8'd0, pend_last, 3'd0);
               pend_in = pend_last ? PENDING_WIDTH'(1) : pend_dec;
               phase_in = pend_last ? PH_START : PH_TYPE;
               if (pend_last) begin
                  intok_in = 1'b0;
                  tcnt_in = '0;
               end
            end else begin
               ev0 = mk_ev(EV_ERR, 3'd0, 64'd0, 8'd0, 1'b0, ERR_CRLF);
               phase_in = PH_START;
               pend_in = PENDING_WIDTH'(1);
               intok_in = 1'b0;
               tcnt_in = '0;
            end
         end
         PH_INLINE: begin
            if (b == CH_LF) begin
               ev0 = mk_ev(EV_END, T_INLINE, {32'd0, tcnt_ff}, 8'd0,
                           !intok_ff, 3'd0);
               ev1 = mk_ev(EV_END, T_INLINE, {32'd0, tcnt_ff}, 8'd0, 1'b1, 3'd0);
               if (intok_ff) begin
                  ev_count = (tcnt_ff != '0) ? 2'd2 : 2'd1;
               end else begin
                  ev_count = (tcnt_ff != '0) ? 2'd1 : 2'd0;
               end
               phase_in = PH_START;
               pend_in = PENDING_WIDTH'(1);
               hcr_in = 1'b0;
               intok_in = 1'b0;
               tcnt_in = '0;
            end else if (is_space(b)) begin
               if (intok_ff) begin
                  ev_count = 2'd1;
                  ev0 = mk_ev(EV_END, T_INLINE, {32'd0, tcnt_ff}, 8'd0, 1'b0, 3'd0);
               end
               intok_in = 1'b0;
            end else if (!intok_ff) begin
               tcnt_in = (tcnt_ff != 32'hFFFF_FFFF) ? tcnt_ff + 32'd1 : tcnt_ff;
               intok_in = 1'b1;
               ev_count = 2'd2;
               ev0 = mk_ev(EV_HEAD, T_INLINE, {32'd0, tcnt_in}, 8'd0, 1'b0, 3'd0);
               ev1 = mk_ev(EV_DATA, T_INLINE, 64'd0, b, 1'b0, 3'd0);
            end else begin
               ev_count = 2'd1;
               ev0 = mk_ev(EV_DATA, T_INLINE, 64'd0, b, 1'b0, 3'd0);
            end
         end
         default: begin
            phase_in = PH_START;
            pend_in = PENDING_WIDTH'(1);
            hcr_in = 1'b0;
            intok_in = 1'b0;
            tcnt_in = '0;
         end
      endcase
   end

endmodule

// ===== design/rrsp_out_queue.sv =====
// Four-entry result queue: up to two events in per cycle, one out while out_ready.
module rrsp_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_count,
   input  rrsp_pkg::event_type push0,
   input  rrsp_pkg::event_type push1,
   output logic                space_ok,
   output logic                out_valid,
   input  logic                out_ready,
   output rrsp_pkg::event_type out_ev,
   output logic                out_last
);
   import rrsp_pkg::*;

   event_type  ev_ff [4];
   logic       last_ff [4];
   logic [1:0] rd_ff, rd_in;
   logic [1:0] wr_ff, wr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop = out_valid && out_ready;
   assign out_valid = (cnt_ff != 3'd0);
   assign out_ev = ev_ff[rd_ff];
   assign out_last = last_ff[rd_ff];
   // Room for two more beats, not counting any pop this cycle.
   assign space_ok = (cnt_ff <= 3'd2);

   always_comb begin
      rd_in = pop ? rd_ff + 2'd1 : rd_ff;
      wr_in = wr_ff + push_count;
      cnt_in = cnt_ff + {1'b0, push_count} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   // Payload storage for the queue entries.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         ev_ff[wr_ff] <= push0;
         last_ff[wr_ff] <= (push_count == 2'd1);
      end
      if (push_count == 2'd2) begin
         ev_ff[wr_ff + 2'd1] <= push1;
         last_ff[wr_ff + 2'd1] <= 1'b1;
      end
   end

endmodule

// ===== design/resp_reply_stream_parser_core.sv =====
// Top level of the RESP reply stream parser.
// One byte beat is taken per cycle and decoded in the same cycle into up to two event
// beats, which go into a four-entry result queue; a byte is taken whenever the queue
// has room for two more beats, so the rate is one byte per cycle as long as the result
// side drains about as fast as events are made. The event beats of a byte are registered
// in the queue and offered in order behind any beats still waiting there. Since at most
// one beat drains per cycle, a run of two-event bytes slows intake. The array limit
// register is written via csr_wr_en.
module resp_reply_stream_parser_core #(
   parameter int PENDING_WIDTH = rrsp_pkg::PENDING_WIDTH_DEFAULT,
   parameter int MAX_INT_CHARS = rrsp_pkg::MAX_INT_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [2:0]  rsp_reply_type,
   output logic signed [63:0] rsp_value,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_message_done,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last_of_run,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data
);
   import rrsp_pkg::*;

   logic [30:0] max_cnt_ff;
   logic        step;
   logic [1:0]  ev_count;
   logic [1:0]  push_count;
   event_type   ev0, ev1, out_ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cnt_ff <= ARRAY_RESET_LIMIT;
      end else if (csr_wr_en) begin
         max_cnt_ff <= csr_wr_data;
      end
   end

   assign step = req_valid && req_ready;
   assign push_count = step ? ev_count : 2'd0;

   rrsp_engine #(
      .PENDING_WIDTH(PENDING_WIDTH),
      .MAX_INT_CHARS(MAX_INT_CHARS)
   ) u_engine (
      .clock(clock), .reset(reset), .step(step), .data_byte(req_data_byte),
      .max_array_count(max_cnt_ff), .ev_count(ev_count), .ev0(ev0), .ev1(ev1)
   );

   rrsp_out_queue u_queue (
      .clock(clock), .reset(reset), .push_count(push_count), .push0(ev0),
      .push1(ev1), .space_ok(req_ready), .out_valid(rsp_valid),
      .out_ready(rsp_ready), .out_ev(out_ev), .out_last(rsp_last_of_run)
   );

   assign rsp_event_kind = out_ev.kind;
   assign rsp_reply_type = out_ev.rtype;
   assign rsp_value = out_ev.value;
   assign rsp_payload_byte = out_ev.pbyte;
   assign rsp_message_done = out_ev.done;
   assign rsp_error_code = out_ev.code;

endmodule
